>>> rtl/bcd_time_frame_parser_assert.svh
// ----------------------------------------------------------------------------
// bcd_time_frame_parser_assert.svh
// assertion macros for the bcd time frame parser; they expect i_clk and i_rst_n
// in the enclosing module
// ----------------------------------------------------------------------------
`ifndef BCD_TIME_FRAME_PARSER_ASSERT_SVH
`define BCD_TIME_FRAME_PARSER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BTFP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("btfp assertion failed");

// next-cycle implication, checked outside reset
`define BTFP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("btfp assertion failed");

`endif

>>> rtl/btfp_pkg.sv
// ----------------------------------------------------------------------------
// btfp_pkg
// constants and helpers for the bcd time frame parser
// ----------------------------------------------------------------------------
package btfp_pkg;

    // frame bytes
    localparam logic [7:0] HEADER_BYTE  = 8'h01;
    localparam logic [7:0] TRAILER_BYTE = 8'hAA;

    // range limits and bcd digit limits
    localparam logic [7:0] HOUR_LIMIT   = 8'd24;
    localparam logic [7:0] MINSEC_LIMIT = 8'd60;
    localparam logic [3:0] DIGIT_MAX    = 4'd9;
    localparam logic [3:0] DIGIT_BASE   = 4'd10;

    // frame position codes
    localparam logic [2:0] POS_HUNT    = 3'd0;
    localparam logic [2:0] POS_HOUR    = 3'd1;
    localparam logic [2:0] POS_MINUTE  = 3'd2;
    localparam logic [2:0] POS_SECOND  = 3'd3;
    localparam logic [2:0] POS_TRAILER = 3'd4;

    // both nibbles are decimal digits
    function automatic logic digits_ok(input logic [7:0] v);
        return (v[7:4] <= DIGIT_MAX) && (v[3:0] <= DIGIT_MAX);
    endfunction

    // packed bcd to binary, tens * 10 + ones
    function automatic logic [7:0] bcd_value(input logic [7:0] v);
        return ({4'd0, v[7:4]} * {4'd0, DIGIT_BASE}) + {4'd0, v[3:0]};
    endfunction

endpackage

>>> rtl/bcd_time_frame_parser.sv
// ----------------------------------------------------------------------------
// bcd_time_frame_parser
// hunts for a header byte, stores bcd hour, minute and second, checks the
// trailer and the digit ranges and emits the binary time
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  rx      | in        | i_rx_valid / o_rx_ready     | i_rx_byte
//  time    | out       | o_time_valid / i_time_ready | o_hours, o_minutes, o_seconds
//
//  one byte per cycle when not stalled; a valid frame's time result appears in the cycle after its trailer transfer
//  reset (i_rst_n low, synchronous) returns the parser to header hunting
//  header and data bytes are taken even while a result waits in the output register
//  only a trailer byte stalls, and only while the output register is full and not taken
module bcd_time_frame_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_time_valid,
    input  logic       i_time_ready,
    output logic [4:0] o_hours,
    output logic [5:0] o_minutes,
    output logic [5:0] o_seconds
);

    `include "bcd_time_frame_parser_assert.svh"

    logic [2:0] r_pos;
    logic [2:0] n_pos;
    logic [7:0] r_bcd_hour;
    logic [7:0] r_bcd_min;
    logic [7:0] r_bcd_sec;
    logic       r_out_valid;
    logic [4:0] r_hours;
    logic [5:0] r_minutes;
    logic [5:0] r_seconds;

    logic       w_at_end;
    logic       w_rx_xfer;
    logic       w_frame_ok;
    logic       w_emit;
    logic [7:0] w_hour_bin;
    logic [7:0] w_min_bin;
    logic [7:0] w_sec_bin;

    // trailer position, unused codes behave the same
    assign w_at_end   = (r_pos >= btfp_pkg::POS_TRAILER);
    assign o_rx_ready = !w_at_end || !r_out_valid || i_time_ready;
    assign w_rx_xfer  = i_rx_valid && o_rx_ready;

    // frame check on the stored fields
    assign w_hour_bin = btfp_pkg::bcd_value(r_bcd_hour);
    assign w_min_bin  = btfp_pkg::bcd_value(r_bcd_min);
    assign w_sec_bin  = btfp_pkg::bcd_value(r_bcd_sec);
    assign w_frame_ok = (i_rx_byte == btfp_pkg::TRAILER_BYTE)
                     && btfp_pkg::digits_ok(r_bcd_hour)
                     && btfp_pkg::digits_ok(r_bcd_min)
                     && btfp_pkg::digits_ok(r_bcd_sec)
                     && (w_hour_bin < btfp_pkg::HOUR_LIMIT)
                     && (w_min_bin < btfp_pkg::MINSEC_LIMIT)
                     && (w_sec_bin < btfp_pkg::MINSEC_LIMIT);
    assign w_emit     = w_rx_xfer && w_at_end && w_frame_ok;

    // next frame position
    always_comb begin
        n_pos = r_pos;
        if (w_rx_xfer) begin
            case (r_pos)
                btfp_pkg::POS_HUNT: begin
                    if (i_rx_byte == btfp_pkg::HEADER_BYTE) begin
                        n_pos = btfp_pkg::POS_HOUR;
                    end
                end
                btfp_pkg::POS_HOUR:   n_pos = btfp_pkg::POS_MINUTE;
                btfp_pkg::POS_MINUTE: n_pos = btfp_pkg::POS_SECOND;
                btfp_pkg::POS_SECOND: n_pos = btfp_pkg::POS_TRAILER;
                default:              n_pos = btfp_pkg::POS_HUNT;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= btfp_pkg::POS_HUNT;
            r_out_valid <= 1'b0;
        end else begin
            r_pos <= n_pos;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_time_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // bcd field store
    always_ff @(posedge i_clk) begin
        if (w_rx_xfer && (r_pos == btfp_pkg::POS_HOUR)) begin
            r_bcd_hour <= i_rx_byte;
        end
        if (w_rx_xfer && (r_pos == btfp_pkg::POS_MINUTE)) begin
            r_bcd_min <= i_rx_byte;
        end
        if (w_rx_xfer && (r_pos == btfp_pkg::POS_SECOND)) begin
            r_bcd_sec <= i_rx_byte;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_hours   <= w_hour_bin[4:0];
            r_minutes <= w_min_bin[5:0];
            r_seconds <= w_sec_bin[5:0];
        end
    end

    assign o_time_valid = r_out_valid;
    assign o_hours      = r_hours;
    assign o_minutes    = r_minutes;
    assign o_seconds    = r_seconds;

    // checks
    `BTFP_ASSERT_NOW(a_pos_range, 1'b1, r_pos <= btfp_pkg::POS_TRAILER)
    `BTFP_ASSERT_NEXT(a_header_starts,
        w_rx_xfer && (r_pos == btfp_pkg::POS_HUNT)
            && (i_rx_byte == btfp_pkg::HEADER_BYTE),
        r_pos == btfp_pkg::POS_HOUR)
    `BTFP_ASSERT_NOW(a_result_from_trailer, $rose(r_out_valid),
        $past(w_rx_xfer) && ($past(r_pos) == btfp_pkg::POS_TRAILER))
    `BTFP_ASSERT_NOW(a_result_range, r_out_valid,
        (r_hours < 5'd24) && (r_minutes < 6'd60) && (r_seconds < 6'd60))

endmodule

>>> sim/bcd_time_frame_parser_checker.sv
// ----------------------------------------------------------------------------
// bcd_time_frame_parser_checker
// watches the rx and time channels of the bcd time frame parser, predicts the
// binary time that each accepted trailer should produce and compares every
// time transfer field by field with the oldest prediction
// ----------------------------------------------------------------------------
module bcd_time_frame_parser_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    input  logic       i_rx_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_time_valid,
    input  logic       i_time_ready,
    input  logic [4:0] i_hours,
    input  logic [5:0] i_minutes,
    input  logic [5:0] i_seconds,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
    } t_clock_time;

    // predicted parser state
    logic [2:0]  frame_pos;
    logic [7:0]  bcd_store [3];
    t_clock_time expected_times [$];
    int          mismatches = 0;

    // advance the predicted parser by one received byte
    task automatic parse_rx_byte(input logic [7:0] value);
        int          tens [3];
        int          ones [3];
        int          hour;
        int          minute;
        int          second;
        bit          digits_valid;
        t_clock_time stamp;
        if (frame_pos == btfp_pkg::POS_HUNT) begin
            if (value == btfp_pkg::HEADER_BYTE) frame_pos = btfp_pkg::POS_HOUR;
        end else if (frame_pos <= btfp_pkg::POS_SECOND) begin
            bcd_store[frame_pos - btfp_pkg::POS_HOUR] = value;
            frame_pos = frame_pos + 3'd1;
        end else begin
            // trailer position, or any unused code: this byte closes the frame
            frame_pos = btfp_pkg::POS_HUNT;
            digits_valid = 1'b1;
            for (int k = 0; k < 3; k++) begin
                tens[k] = bcd_store[k][7:4];
                ones[k] = bcd_store[k][3:0];
                if (tens[k] > btfp_pkg::DIGIT_MAX || ones[k] > btfp_pkg::DIGIT_MAX) begin
                    digits_valid = 1'b0;
                end
            end
            if (value == btfp_pkg::TRAILER_BYTE && digits_valid) begin
                hour   = tens[0] * btfp_pkg::DIGIT_BASE + ones[0];
                minute = tens[1] * btfp_pkg::DIGIT_BASE + ones[1];
                second = tens[2] * btfp_pkg::DIGIT_BASE + ones[2];
                if (hour < btfp_pkg::HOUR_LIMIT && minute < btfp_pkg::MINSEC_LIMIT
                        && second < btfp_pkg::MINSEC_LIMIT) begin
                    stamp.hours   = hour[4:0];
                    stamp.minutes = minute[5:0];
                    stamp.seconds = second[5:0];
                    expected_times.push_back(stamp);
                end
            end
        end
    endtask

    // compare one time transfer with the oldest prediction
    task automatic check_time_transfer();
        t_clock_time want;
        if (expected_times.size() == 0) begin
            $display("%0t: unexpected time transfer, expected none, actual %0d:%0d:%0d",
                     $time, i_hours, i_minutes, i_seconds);
            mismatches++;
        end else begin
            want = expected_times.pop_front();
            if (i_hours !== want.hours) begin
                $display("%0t: hours mismatch, expected %0d, actual %0d",
                         $time, want.hours, i_hours);
                mismatches++;
            end
            if (i_minutes !== want.minutes) begin
                $display("%0t: minutes mismatch, expected %0d, actual %0d",
                         $time, want.minutes, i_minutes);
                mismatches++;
            end
            if (i_seconds !== want.seconds) begin
                $display("%0t: seconds mismatch, expected %0d, actual %0d",
                         $time, want.seconds, i_seconds);
                mismatches++;
            end
        end
    endtask

    // sample both channels at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_pos = btfp_pkg::POS_HUNT;
            expected_times.delete();
        end else begin
            if (i_time_valid === 1'b1 && i_time_ready === 1'b1) check_time_transfer();
            if (i_rx_valid === 1'b1 && i_rx_ready === 1'b1) parse_rx_byte(i_rx_byte);
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_times.size();
    end

endmodule

>>> sim/bcd_time_frame_parser_tb.sv
// ----------------------------------------------------------------------------
// bcd_time_frame_parser_tb
// drives received bytes into the bcd time frame parser: a few directed frames,
// then mostly well-formed frames with random content mixed with noise and
// broken frames, under three idling mixes and one long receiver hold-off
// ----------------------------------------------------------------------------
module bcd_time_frame_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_rx_valid   = 1'b0;
    logic [7:0] i_rx_byte    = 8'h00;
    logic       i_time_ready = 1'b0;
    logic       o_rx_ready;
    logic       o_time_valid;
    logic [4:0] o_hours;
    logic [5:0] o_minutes;
    logic [5:0] o_seconds;

    int fail_count;
    int pending_times;
    int tx_idle_pct   = 14;
    int rx_idle_pct   = 47;
    int bytes_sent    = 0;
    bit hold_toggle   = 1'b0;
    bit hold_seen     = 1'b0;
    int hold_left     = 0;

    // clock, 8 ns period
    always #4 i_clk = ~i_clk;

    bcd_time_frame_parser i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_valid   (i_rx_valid),
        .o_rx_ready   (o_rx_ready),
        .i_rx_byte    (i_rx_byte),
        .o_time_valid (o_time_valid),
        .i_time_ready (i_time_ready),
        .o_hours      (o_hours),
        .o_minutes    (o_minutes),
        .o_seconds    (o_seconds)
    );

    bcd_time_frame_parser_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_valid   (i_rx_valid),
        .i_rx_ready   (o_rx_ready),
        .i_rx_byte    (i_rx_byte),
        .i_time_valid (o_time_valid),
        .i_time_ready (i_time_ready),
        .i_hours      (o_hours),
        .i_minutes    (o_minutes),
        .i_seconds    (o_seconds),
        .o_fail_count (fail_count),
        .o_pending    (pending_times)
    );

    // time receiver: random stalls, or a long hold-off when the top asks for one
    always @(posedge i_clk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen    <= hold_toggle;
            hold_left    <= 400;
            i_time_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            i_time_ready <= 1'b0;
        end else begin
            i_time_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // binary 0..99 to packed bcd
    function automatic logic [7:0] to_bcd(input int value);
        logic [3:0] tens;
        logic [3:0] ones;
        tens = 4'(value / 10);
        ones = 4'(value % 10);
        return {tens, ones};
    endfunction

    // one frame field: mostly in range, sometimes out of range, bad digits or header
    function automatic logic [7:0] pick_bcd_field(input int limit);
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 13) return to_bcd($urandom_range(0, limit - 1));
        if (pick < 15) return to_bcd(limit - 1);
        if (pick < 17) return to_bcd($urandom_range(limit, 99));
        if (pick < 19) return 8'($urandom_range(0, 255));
        return btfp_pkg::HEADER_BYTE;
    endfunction

    // offer one byte, with random idle cycles first, and wait for its transfer
    task automatic send_rx_byte(input logic [7:0] value);
        bit ready_seen;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_rx_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= value;
        ready_seen = 1'b0;
        while (!ready_seen) begin
            @(negedge i_clk);
            ready_seen = o_rx_ready;
            @(posedge i_clk);
        end
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] hour, input logic [7:0] minute,
                              input logic [7:0] second, input logic [7:0] trailer);
        send_rx_byte(btfp_pkg::HEADER_BYTE);
        send_rx_byte(hour);
        send_rx_byte(minute);
        send_rx_byte(second);
        send_rx_byte(trailer);
    endtask

    // random frames with noise between them, until the byte budget is spent
    task automatic run_random_traffic(input int byte_budget);
        int          stop_at;
        int          noise;
        logic [7:0]  trailer;
        stop_at = bytes_sent + byte_budget;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(0, 99) < 20) begin
                noise = $urandom_range(1, 3);
                repeat (noise) send_rx_byte(8'($urandom_range(0, 255)));
            end
            trailer = ($urandom_range(0, 99) < 85) ? btfp_pkg::TRAILER_BYTE
                                                   : 8'($urandom_range(0, 255));
            send_frame(pick_bcd_field(24), pick_bcd_field(60), pick_bcd_field(60), trailer);
        end
    endtask

    // main stimulus
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: noise, midnight, last second, header as data,
        // out of range with bad digits, wrong trailer
        send_rx_byte(8'hFF);
        send_frame(8'h00, 8'h00, 8'h00, btfp_pkg::TRAILER_BYTE);
        send_frame(8'h23, 8'h59, 8'h59, btfp_pkg::TRAILER_BYTE);
        send_frame(btfp_pkg::HEADER_BYTE, btfp_pkg::HEADER_BYTE, btfp_pkg::HEADER_BYTE,
                   btfp_pkg::TRAILER_BYTE);
        send_frame(8'h24, 8'h60, 8'h5A, btfp_pkg::TRAILER_BYTE);
        send_frame(8'h12, 8'h34, 8'h56, 8'h55);

        // sender idles lightly, receiver heavily
        run_random_traffic(400);

        // the other way round
        tx_idle_pct = 47;
        rx_idle_pct <= 14;
        run_random_traffic(400);

        // no idling, with one long receiver hold-off up front
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        hold_toggle <= ~hold_toggle;
        run_random_traffic(400);

        // drain
        i_rx_valid <= 1'b0;
        do @(posedge i_clk); while (pending_times != 0);
        repeat (20) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // run limit
    initial begin
        #1000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
